// File: hdl/chip_pkg.sv
// Package: constants, codes and types shared by the chained hash index pool.
`timescale 1ns / 1ps
package chip_pkg;
  localparam int BUCKET_COUNT = 1024;
  localparam int POOL_ENTRIES = 4096;
  localparam int TAG_BITS     = 12;
  localparam int LINK_W       = 20;
  localparam int IDX_W        = $clog2(POOL_ENTRIES);
  localparam int STEP_W       = IDX_W + 1;
  localparam int BKT_W        = $clog2(BUCKET_COUNT);
  localparam int NB_W         = 11;
  localparam int ID_W         = 32;
  localparam int LOC_W        = 32;
  localparam int HITS_W       = 8;
  localparam int DIV_CNT_W    = $clog2(ID_W);
  localparam logic [LINK_W-1:0] LINK_NONE = 20'hfffff;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_COUNT  = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [LINK_W-1:0]   link;
    logic [HITS_W-1:0]   hits;
    logic [LOC_W-1:0]    loc;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_HEAD, S_LOOK, S_CHK,
    S_UNLINK, S_ALLOC, S_LINK, S_DONE
  } state_t;
endpackage

// File: hdl/chip_if.sv
// Interfaces: command word channel and result word channel.
`timescale 1ns / 1ps
interface chip_in_if;
  import chip_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [ID_W-1:0]     bucket_id;
  logic [TAG_BITS-1:0] key_tag;
  logic [LOC_W-1:0]    location_in;
  logic [HITS_W-1:0]   hits_in;
  modport source (output valid, command, bucket_id, key_tag, location_in, hits_in,
                  input ready);
  modport sink (input valid, command, bucket_id, key_tag, location_in, hits_in,
                output ready);
endinterface

interface chip_out_if;
  import chip_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [LOC_W-1:0]  location_out;
  logic [HITS_W-1:0] hits_out;
  modport source (output valid, status, location_out, hits_out, input ready);
  modport sink (input valid, status, location_out, hits_out, output ready);
endinterface

// File: hdl/chained_hash_index_pool.sv
// Top level: chained hash index with bucket-head memory, entry pool memory and sequencer.
//
// Commands arrive as words on in_ch (valid/ready); one result word per command
// leaves on out_ch. Commands: lookup, lookup counting a hit, insert, remove.
// cfg_we/cfg_data write the bucket count (0 acts as 1, above 1024 as 1024).
// Write only while no command is in flight; the block does not enforce it.
// Each command goes through an accept step, the serial bucket modulo, a head
// read, then one entry memory read and check per chain entry visited, one
// more look at the chain end when nothing matches, any write-back, and the
// load of the result register.
// One command is in work at a time; the next word is taken while the result
// word still waits in the output register.
// If the receiver stalls, the block finishes the command in hand and holds in
// its final state until the result register frees up.
// After reset a clearing pass writes every bucket head empty, during which
// in_ch.ready is low. Pool entries need no clearing: the high-water mark
// gates their valid bits.
`timescale 1ns / 1ps
module chained_hash_index_pool
  import chip_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  chip_in_if.sink         in_ch,
  chip_out_if.source      out_ch,
  input  logic            cfg_we,
  input  logic [NB_W-1:0] cfg_data
);
  state_t state_r, state_nxt;

  logic [NB_W-1:0]     nb_r;
  logic [BKT_W-1:0]    clr_r;
  logic [BKT_W-1:0]    bucket_r;
  logic [1:0]          cmd_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [LOC_W-1:0]    loc_r;
  logic [HITS_W-1:0]   hin_r;
  logic [LINK_W-1:0]   cur_r;
  logic [LINK_W-1:0]   prev_r;
  logic [STEP_W-1:0]   steps_r;
  logic [LINK_W-1:0]   fh_r;
  logic [STEP_W-1:0]   hw_r;
  logic [IDX_W-1:0]    ni_r;
  entry_t              prev_e_r;
  logic [1:0]          st_r;
  logic [LOC_W-1:0]    lo_r;
  logic [HITS_W-1:0]   ho_r;
  logic                out_valid_r;
  logic [1:0]          out_st_r;
  logic [LOC_W-1:0]    out_lo_r;
  logic [HITS_W-1:0]   out_ho_r;

  logic [LINK_W-1:0] head_mem [BUCKET_COUNT];
  logic              head_we;
  logic [BKT_W-1:0]  head_wa;
  logic [LINK_W-1:0] head_wd;
  logic              head_re;
  logic [BKT_W-1:0]  head_ra;
  logic [LINK_W-1:0] head_q;

  entry_t           ent_mem [POOL_ENTRIES];
  logic             ent_we;
  logic [IDX_W-1:0] ent_wa;
  entry_t           ent_wd;
  logic             ent_re;
  logic [IDX_W-1:0] ent_ra;
  entry_t           ent_q;

  logic            accept;
  logic            mod_done;
  logic [NB_W-1:0] mod_rem;
  logic [NB_W-1:0] nb_clamp;
  logic            chain_end;
  logic            match;
  logic            prev_ok;
  logic            fh_eq_hw;
  logic            hw_full;
  logic            fh_bad;
  logic            out_free;
  logic [HITS_W-1:0] hits_inc;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign chain_end = (cur_r >= LINK_W'(POOL_ENTRIES)) || (steps_r == STEP_W'(POOL_ENTRIES));
  assign match = ent_q.valid && (cur_r < LINK_W'(hw_r)) && (ent_q.tag == tag_r) &&
                 ((cmd_r != CMD_REMOVE) || (ent_q.loc == loc_r));
  assign prev_ok  = prev_r < LINK_W'(POOL_ENTRIES);
  assign fh_eq_hw = fh_r == LINK_W'(hw_r);
  assign hw_full  = hw_r >= STEP_W'(POOL_ENTRIES);
  assign fh_bad   = fh_r >= LINK_W'(POOL_ENTRIES);
  assign hits_inc = (ent_q.hits == '1) ? ent_q.hits : ent_q.hits + 1'b1;

  always_comb begin
    nb_clamp = cfg_data;
    if (cfg_data == '0) nb_clamp = NB_W'(1);
    else if (cfg_data > NB_W'(BUCKET_COUNT)) nb_clamp = NB_W'(BUCKET_COUNT);
  end

  chip_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (in_ch.bucket_id),
    .divisor  (nb_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (ent_re) ent_q <= ent_mem[ent_ra];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == BKT_W'(BUCKET_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_DIV;
      S_DIV:   if (mod_done) state_nxt = S_HEAD;
      S_HEAD:  state_nxt = S_LOOK;
      S_LOOK: begin
        if (!chain_end) state_nxt = S_CHK;
        else if (cmd_r != CMD_INSERT) state_nxt = S_DONE;
        else if (fh_eq_hw) state_nxt = (!hw_full && prev_ok) ? S_LINK : S_DONE;
        else state_nxt = fh_bad ? S_DONE : S_ALLOC;
      end
      S_CHK: begin
        if (!match) state_nxt = S_LOOK;
        else if (cmd_r == CMD_REMOVE) state_nxt = S_UNLINK;
        else state_nxt = S_DONE;
      end
      S_UNLINK: state_nxt = S_DONE;
      S_ALLOC:  state_nxt = prev_ok ? S_LINK : S_DONE;
      S_LINK:   state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    head_we = 1'b0;
    head_wa = bucket_r;
    head_wd = LINK_NONE;
    head_re = 1'b0;
    head_ra = mod_rem[BKT_W-1:0];
    ent_we  = 1'b0;
    ent_wa  = cur_r[IDX_W-1:0];
    ent_wd  = ent_q;
    ent_re  = 1'b0;
    ent_ra  = cur_r[IDX_W-1:0];
    case (state_r)
      S_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_r;
      end
      S_DIV: head_re = mod_done;
      S_LOOK: begin
        if (!chain_end) begin
          ent_re = 1'b1;
        end else if (cmd_r == CMD_INSERT) begin
          if (fh_eq_hw) begin
            if (!hw_full) begin
              ent_we = 1'b1;
              ent_wa = hw_r[IDX_W-1:0];
              ent_wd = '{valid: 1'b1, link: LINK_NONE, hits: hin_r, loc: loc_r, tag: tag_r};
              if (!prev_ok) begin
                head_we = 1'b1;
                head_wd = LINK_W'(hw_r);
              end
            end
          end else if (!fh_bad) begin
            ent_re = 1'b1;
            ent_ra = fh_r[IDX_W-1:0];
          end
        end
      end
      S_CHK: begin
        if (match) begin
          case (cmd_r)
            CMD_COUNT: begin
              ent_we = 1'b1;
              ent_wd.hits = hits_inc;
            end
            CMD_INSERT: begin
              ent_we = 1'b1;
              ent_wd.hits = hin_r;
              ent_wd.loc  = loc_r;
              ent_wd.tag  = tag_r;
            end
            CMD_REMOVE: begin
              ent_we = 1'b1;
              ent_wd.valid = 1'b0;
              ent_wd.link  = fh_r;
              if (!prev_ok) begin
                head_we = 1'b1;
                head_wd = ent_q.link;
              end
            end
            default: ;
          endcase
        end
      end
      S_UNLINK: begin
        if (prev_ok) begin
          ent_we = 1'b1;
          ent_wa = prev_r[IDX_W-1:0];
          ent_wd = prev_e_r;
          ent_wd.link = ent_q.link;
        end
      end
      S_ALLOC: begin
        ent_we = 1'b1;
        ent_wa = fh_r[IDX_W-1:0];
        ent_wd = '{valid: 1'b1, link: LINK_NONE, hits: hin_r, loc: loc_r, tag: tag_r};
        if (!prev_ok) begin
          head_we = 1'b1;
          head_wd = fh_r;
        end
      end
      S_LINK: begin
        ent_we = 1'b1;
        ent_wa = prev_r[IDX_W-1:0];
        ent_wd = prev_e_r;
        ent_wd.link = LINK_W'(ni_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      nb_r        <= NB_W'(BUCKET_COUNT);
      fh_r        <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_we) nb_r <= nb_clamp;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == S_LOOK && chain_end && cmd_r == CMD_INSERT && fh_eq_hw && !hw_full) begin
        hw_r <= hw_r + 1'b1;
        fh_r <= LINK_W'(hw_r + 1'b1);
      end
      if (state_r == S_ALLOC) fh_r <= ent_q.link;
      if (state_r == S_CHK && match && cmd_r == CMD_REMOVE) fh_r <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_r <= in_ch.command;
          tag_r <= in_ch.key_tag;
          loc_r <= in_ch.location_in;
          hin_r <= in_ch.hits_in;
        end
      end
      S_DIV: if (mod_done) bucket_r <= mod_rem[BKT_W-1:0];
      S_HEAD: begin
        cur_r   <= head_q;
        prev_r  <= LINK_NONE;
        steps_r <= '0;
        st_r    <= ST_MISS;
        lo_r    <= '0;
        ho_r    <= '0;
      end
      S_LOOK: begin
        if (chain_end && cmd_r == CMD_INSERT) begin
          if (fh_eq_hw) begin
            st_r <= hw_full ? ST_FULL : ST_OK;
            ni_r <= hw_r[IDX_W-1:0];
          end else begin
            st_r <= fh_bad ? ST_FULL : ST_OK;
            ni_r <= fh_r[IDX_W-1:0];
          end
        end
      end
      S_CHK: begin
        if (match) begin
          st_r <= ST_OK;
          if (cmd_r == CMD_LOOKUP || cmd_r == CMD_COUNT) begin
            lo_r <= ent_q.loc;
            ho_r <= (cmd_r == CMD_COUNT) ? hits_inc : ent_q.hits;
          end
        end else begin
          prev_r   <= cur_r;
          prev_e_r <= ent_q;
          cur_r    <= ent_q.link;
          steps_r  <= steps_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_st_r <= st_r;
          out_lo_r <= lo_r;
          out_ho_r <= ho_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.location_out = out_lo_r;
  assign out_ch.hits_out     = out_ho_r;

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= STEP_W'(POOL_ENTRIES)) else $error("high-water mark past pool");
  a_chk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK |-> cur_r < LINK_W'(POOL_ENTRIES)) else $error("check on bad index");
  a_alloc_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC |-> fh_r < LINK_W'(POOL_ENTRIES)) else $error("alloc from bad free head");
  a_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HEAD |-> NB_W'(bucket_r) < nb_r) else $error("bucket past count");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("result not loaded");
endmodule

// File: hdl/chip_mod.sv
// Bit-serial modulo unit: bucket id reduced by the bucket count.
`timescale 1ns / 1ps
module chip_mod
  import chip_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [ID_W-1:0] dividend,
  input  logic [NB_W-1:0] divisor,
  output logic            done,
  output logic [NB_W-1:0] rem
);
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [ID_W-1:0]      dvd_r;
  logic [NB_W-1:0]      rem_r;
  logic [NB_W-1:0]      dsr_r;
  logic [NB_W:0]        t;
  logic                 ge;
  logic [NB_W-1:0]      rem_nxt;

  always_comb begin
    t       = {rem_r, dvd_r[ID_W-1]};
    ge      = t >= {1'b0, dsr_r};
    rem_nxt = ge ? NB_W'(t - {1'b0, dsr_r}) : t[NB_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == DIV_CNT_W'(ID_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(ID_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[ID_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
